### rtl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared types and constants for the one-shot timer bank.
// ----------------------------------------------------------------------------
package otb_pkg;

	localparam int TIMERS_DEFAULT = 8;
	localparam int COUNT_W = 16;
	localparam int MASK_W = 8;
	localparam int LIMIT_W = 8;
	localparam logic [LIMIT_W-1:0] PRESCALE_LIMIT_RESET = 8'd40;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [2:0]         timer_index;
		logic [COUNT_W-1:0] start_count;
	} in_word_t;

	typedef struct packed {
		logic [MASK_W-1:0] expired_mask;
		logic [MASK_W-1:0] running_mask;
		logic              protocol_pulse;
	} out_word_t;

	// count load from a start word, write port of the count memory
	typedef struct packed {
		logic               valid;
		logic [5:0]         idx;
		logic [COUNT_W-1:0] count;
	} load_t;

	// per-timer outcome of the sweep unit
	typedef struct packed {
		logic       fire;
		logic       expire;
		logic       last;
		logic [5:0] idx;
	} sweep_upd_t;

endpackage

### rtl/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank
// Bank of one-shot countdown timers with a shared tick prescaler.
// ----------------------------------------------------------------------------
// A command word is taken on a clock edge with start high and busy low.
// func tick advances the prescaler and steps every timer, start loads and
// arms one timer, stop disarms it and clears its expired flag.
// Every word gives exactly one result word, shown on result for one cycle
// with done high; the receiver cannot hold it off.
// Start, stop and unused codes: result in the cycle after the edge that
// took the word, busy stays low, so such words can come every cycle.
// Tick: the timers are stepped one per cycle through a single count memory
// and one decrementer, so busy is high while the sweep reads each timer
// and writes its count back, and the result word appears once the last
// timer has been stepped, when busy has gone low again.
// The user must write prescale_limit (wr_en, wr_data) only while idle; the
// bank does not enforce this. Reset clears all flags, the prescaler and the
// pending result, and sets the limit to 40. Counts of disarmed timers are
// never looked at, so the count memory needs no clearing pass.
// ----------------------------------------------------------------------------
module one_shot_timer_bank #(
	parameter int TIMERS = otb_pkg::TIMERS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  otb_pkg::in_word_t           cmd,
	output logic                        done,
	output otb_pkg::out_word_t          result,
	input  logic                        wr_en,
	input  logic [otb_pkg::LIMIT_W-1:0] wr_data
);

	localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	logic [TIMERS-1:0]           armed_q;
	logic [TIMERS-1:0]           expired_q;
	logic [TIMERS-1:0]           armed_d;
	logic [TIMERS-1:0]           expired_d;
	logic [otb_pkg::LIMIT_W-1:0] limit_q;
	logic [otb_pkg::LIMIT_W-1:0] prescaler_q;
	logic                        pulse_q;
	logic                        done_q;
	otb_pkg::out_word_t          result_q;

	logic                        accept;
	logic                        in_range;
	logic [TW-1:0]               idx;
	logic                        emit;
	logic                        emit_pulse;
	logic [otb_pkg::MASK_W-1:0]  exp_mask;
	logic [otb_pkg::MASK_W-1:0] run_mask;
	logic                        sweep_busy;
	otb_pkg::load_t              load;
	otb_pkg::sweep_upd_t         upd;

	assign accept = start && !busy;
	assign in_range = (int'(cmd.timer_index) < TIMERS);
	assign idx = TW'(cmd.timer_index);

	assign load.valid = accept && (cmd.func == otb_pkg::FUNC_START) && in_range;
	assign load.idx = 6'(idx);
	assign load.count = cmd.start_count;

	otb_sweep #(
		.TIMERS(TIMERS)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (accept && (cmd.func == otb_pkg::FUNC_TICK)),
		.load  (load),
		.armed (armed_q),
		.busy  (sweep_busy),
		.upd   (upd)
	);

	assign busy = sweep_busy;

	always_comb begin
		armed_d = armed_q;
		expired_d = expired_q;
		if (accept && in_range) begin
			if (cmd.func == otb_pkg::FUNC_START) begin
				armed_d[idx] = 1'b1;
				expired_d[idx] = 1'b0;
			end else if (cmd.func == otb_pkg::FUNC_STOP) begin
				armed_d[idx] = 1'b0;
				expired_d[idx] = 1'b0;
			end
		end
		if (upd.expire) begin
			armed_d[TW'(upd.idx)] = 1'b0;
			expired_d[TW'(upd.idx)] = 1'b1;
		end
	end

	assign emit = (accept && (cmd.func != otb_pkg::FUNC_TICK)) || (upd.fire && upd.last);
	assign emit_pulse = upd.fire && upd.last && pulse_q;

	// only timers 0..7 show in the masks
	for (genvar i = 0; i < otb_pkg::MASK_W; i++) begin : g_mask
		if (i < TIMERS) begin : g_on
			assign exp_mask[i] = expired_d[i];
			assign run_mask[i] = armed_d[i];
		end else begin : g_off
			assign exp_mask[i] = 1'b0;
			assign run_mask[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			expired_q <= '0;
			limit_q <= otb_pkg::PRESCALE_LIMIT_RESET;
			prescaler_q <= '0;
			pulse_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			armed_q <= armed_d;
			expired_q <= expired_d;
			done_q <= emit;
			if (wr_en) begin
				limit_q <= wr_data;
			end
			if (accept && (cmd.func == otb_pkg::FUNC_TICK)) begin
				if (prescaler_q > limit_q) begin
					prescaler_q <= '0;
					pulse_q <= 1'b1;
				end else begin
					prescaler_q <= prescaler_q + otb_pkg::LIMIT_W'(1);
					pulse_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.expired_mask <= exp_mask;
			result_q.running_mask <= run_mask;
			result_q.protocol_pulse <= emit_pulse;
		end
	end

	assign done = done_q;
	assign result = result_q;

	// a timer is never armed and expired at once
	a_flags_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & expired_q) == '0)
		else $error("timer armed and expired at once");

	// a tick keeps the bank busy on the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.func == otb_pkg::FUNC_TICK)) |=> busy)
		else $error("tick taken without sweep");

	// a result word leaves the bank idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while sweep still running");

	// the pulse only ends a sweep
	a_pulse_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.protocol_pulse) |-> $past(upd.fire && upd.last))
		else $error("pulse on a word that was not a tick");

endmodule

### rtl/otb_sweep.sv
// ----------------------------------------------------------------------------
// otb_sweep
// Count memory and shared decrementer; steps through all timers on a tick.
// ----------------------------------------------------------------------------
module otb_sweep #(
	parameter int TIMERS = otb_pkg::TIMERS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  otb_pkg::load_t     load,
	input  logic [TIMERS-1:0]  armed,
	output logic               busy,
	output otb_pkg::sweep_upd_t upd
);

	localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	logic [otb_pkg::COUNT_W-1:0] mem [TIMERS];

	logic                        state_q;
	logic [TW-1:0]               rd_ptr_q;
	logic                        v_s1;
	logic                        last_s1;
	logic [TW-1:0]               idx_s1;
	logic [otb_pkg::COUNT_W-1:0] cnt_s1;

	logic                        rd_last;
	logic                        cnt_gt1;
	logic                        wr_en;
	logic [TW-1:0]               wr_addr;
	logic [otb_pkg::COUNT_W-1:0] wr_data;

	assign rd_last = (rd_ptr_q == TW'(TIMERS - 1));
	assign cnt_gt1 = (cnt_s1 > otb_pkg::COUNT_W'(1));

	// sequencer: one timer read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_ptr_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			last_s1 <= (state_q == ST_SWEEP) && rd_last;
			unique case (state_q)
				ST_IDLE: begin
					rd_ptr_q <= '0;
					if (go) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					rd_ptr_q <= rd_ptr_q + TW'(1);
					if (rd_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q;
		cnt_s1 <= mem[rd_ptr_q];
	end

	// shared decrementer and write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = TW'(load.idx);
		wr_data = load.count;
		if (v_s1) begin
			wr_en = armed[idx_s1] && cnt_gt1;
			wr_addr = idx_s1;
			wr_data = cnt_s1 - otb_pkg::COUNT_W'(1);
		end else if (load.valid) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign busy = (state_q == ST_SWEEP) || v_s1;

	always_comb begin
		upd.fire = v_s1;
		upd.expire = v_s1 && armed[idx_s1] && !cnt_gt1;
		upd.last = last_s1;
		upd.idx = 6'(idx_s1);
	end

endmodule
